[src/trs_pkg.sv]
// Shared constants, register codes and controller/datapath types for the tile sampler.
package trs_pkg;

	// default sizing of the top level
	localparam int MAX_TILE_SIZE_DEF  = 16;
	localparam int MAX_TILES_EDGE_DEF = 256;
	localparam int MAX_CHANNELS_DEF   = 4;

	// fixed field widths
	localparam int TILE_NUM_W  = 18;
	localparam int BYTE_OFF_W  = 10;
	localparam int BYTE_W      = 8;
	localparam int M_TDATA_W   = 40;  // 36 bits of fields, padded to whole bytes
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 9;
	localparam int ORIENT_W    = 2;

	localparam logic [ORIENT_W-1:0] ORIENT_FIRST = 2'd0;
	localparam logic [ORIENT_W-1:0] ORIENT_LAST  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TILES_ACROSS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TILES_DOWN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_ON    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_ON    = 3'd5;

	// register reset values
	localparam logic [4:0] TILE_SIZE_RST    = 5'd3;
	localparam logic [8:0] TILES_ACROSS_RST = 9'd1;
	localparam logic [8:0] TILES_DOWN_RST   = 9'd1;
	localparam logic [2:0] CHANNELS_RST     = 3'd3;

	// controller -> datapath
	typedef struct packed {
		logic                accept;  // latch input beat, step counters
		logic                load;    // fill output register
		logic [ORIENT_W-1:0] orient;  // orientation to emit
	} trs_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic rotate;
	} trs_stat_t;

endpackage

[src/trs_ctrl.sv]
// Controller: accept/emit state machine, orientation count and output valid.
module trs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  trs_pkg::trs_stat_t stat,
	output trs_pkg::trs_cmd_t  cmd
);
	import trs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_BUSY = 2'b10
	} state_t;

	state_t              state_q;
	logic [ORIENT_W-1:0] orient_q;
	logic                out_valid_q;
	logic                can_load;
	logic                last_o;
	logic                load;
	logic                accept;

	assign can_load = !out_valid_q || m_tready;
	assign last_o   = !stat.rotate || (orient_q == ORIENT_LAST);
	assign load     = (state_q == ST_BUSY) && can_load;
	// next byte may enter on the cycle its predecessor's final write is loaded
	assign s_tready = (state_q == ST_IDLE) || (load && last_o);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	assign cmd.accept = accept;
	assign cmd.load   = load;
	assign cmd.orient = orient_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			orient_q    <= ORIENT_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q  <= ST_BUSY;
						orient_q <= ORIENT_FIRST;
					end
				end
				ST_BUSY: begin
					if (load) begin
						if (last_o) begin
							orient_q <= ORIENT_FIRST;
							state_q  <= accept ? ST_BUSY : ST_IDLE;
						end else begin
							orient_q <= orient_q + 1'b1;
						end
					end
				end
				default: begin
					state_q  <= ST_IDLE;
					orient_q <= ORIENT_FIRST;
				end
			endcase
		end
	end

endmodule

[src/trs_dpath.sv]
// Datapath: config registers, position counters, coordinate mapping and output register.
module trs_dpath #(
	parameter int MAX_TILE_SIZE  = trs_pkg::MAX_TILE_SIZE_DEF,
	parameter int MAX_TILES_EDGE = trs_pkg::MAX_TILES_EDGE_DEF,
	parameter int MAX_CHANNELS   = trs_pkg::MAX_CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [trs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [trs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [trs_pkg::BYTE_W-1:0]        s_tdata,
	input  trs_pkg::trs_cmd_t                 cmd,
	output trs_pkg::trs_stat_t                stat,
	output logic [trs_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic                              m_tlast,
	output logic                              m_tuser
);
	import trs_pkg::*;

	localparam int PW  = (MAX_TILE_SIZE > 1) ? $clog2(MAX_TILE_SIZE) : 1;
	localparam int SW  = $clog2(MAX_TILE_SIZE + 1);
	localparam int EW  = (MAX_TILES_EDGE > 1) ? $clog2(MAX_TILES_EDGE) : 1;
	localparam int EEW = $clog2(MAX_TILES_EDGE + 1);
	localparam int KW  = (MAX_TILES_EDGE > 1) ? $clog2(MAX_TILES_EDGE * MAX_TILES_EDGE) : 1;
	localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CEW = $clog2(MAX_CHANNELS + 1);
	localparam int PSW = 2 * SW + 1;
	localparam int OFW = PSW + CEW;

	// configuration
	logic [4:0] tile_size_q;
	logic [8:0] tiles_across_q;
	logic [8:0] tiles_down_q;
	logic [2:0] channels_q;
	logic       rotate_q;
	logic       mirror_q;

	// position counters
	logic [CW-1:0] chan_q;
	logic [PW-1:0] col_q;
	logic [PW-1:0] row_q;
	logic [EW-1:0] tcol_q;
	logic [EW-1:0] trow_q;
	logic [KW-1:0] k_q;

	// current byte
	logic [BYTE_W-1:0] byte_q;
	logic [PW-1:0]     x_q;
	logic [PW-1:0]     y_q;
	logic [CW-1:0]     ch_q;
	logic [KW-1:0]     kit_q;
	logic              done_q;

	// output register
	logic [TILE_NUM_W-1:0] tile_q;
	logic [BYTE_OFF_W-1:0] off_q;
	logic [BYTE_W-1:0]     obyte_q;
	logic                  last_q;
	logic                  imgdone_q;

	logic [SW-1:0]  s_eff;
	logic [EEW-1:0] ta_eff;
	logic [EEW-1:0] td_eff;
	logic [CEW-1:0] c_eff;
	logic [PW-1:0]  m_val;
	logic           cfg_hit;
	logic           last_c, last_x, last_y, last_tc, last_tr, done;
	logic [PW-1:0]  col_sel, row_sel;
	logic [PSW-1:0] pos;
	logic [OFW-1:0] scaled;
	logic [OFW-1:0] off_full;

	// effective register values: zero acts as one, excess acts as the maximum
	always_comb begin
		if (tile_size_q == '0) s_eff = SW'(1);
		else if (32'(tile_size_q) > 32'(MAX_TILE_SIZE)) s_eff = SW'(MAX_TILE_SIZE);
		else s_eff = SW'(tile_size_q);
		if (tiles_across_q == '0) ta_eff = EEW'(1);
		else if (32'(tiles_across_q) > 32'(MAX_TILES_EDGE)) ta_eff = EEW'(MAX_TILES_EDGE);
		else ta_eff = EEW'(tiles_across_q);
		if (tiles_down_q == '0) td_eff = EEW'(1);
		else if (32'(tiles_down_q) > 32'(MAX_TILES_EDGE)) td_eff = EEW'(MAX_TILES_EDGE);
		else td_eff = EEW'(tiles_down_q);
		if (channels_q == '0) c_eff = CEW'(1);
		else if (32'(channels_q) > 32'(MAX_CHANNELS)) c_eff = CEW'(MAX_CHANNELS);
		else c_eff = CEW'(channels_q);
	end

	assign m_val   = PW'(s_eff - SW'(1));
	assign cfg_hit = cfg_valid && (cfg_index <= CFG_MIRROR_ON);
	assign stat.rotate = rotate_q;

	assign last_c  = 32'(chan_q) + 32'd1 >= 32'(c_eff);
	assign last_x  = 32'(col_q)  + 32'd1 >= 32'(s_eff);
	assign last_y  = 32'(row_q)  + 32'd1 >= 32'(s_eff);
	assign last_tc = 32'(tcol_q) + 32'd1 >= 32'(ta_eff);
	assign last_tr = 32'(trow_q) + 32'd1 >= 32'(td_eff);
	assign done    = last_c && last_x && last_y && last_tc && last_tr;

	// destination pixel for the selected orientation
	always_comb begin
		col_sel = x_q;
		row_sel = y_q;
		if (rotate_q) begin
			case (cmd.orient)
				2'd0: begin
					col_sel = x_q;
					row_sel = y_q;
				end
				2'd1: begin
					col_sel = m_val - y_q;
					row_sel = x_q;
				end
				2'd2: begin
					col_sel = mirror_q ? x_q : m_val - x_q;
					row_sel = m_val - y_q;
				end
				2'd3: begin
					col_sel = y_q;
					row_sel = m_val - x_q;
				end
				default: begin
					col_sel = x_q;
					row_sel = y_q;
				end
			endcase
		end
	end

	// channel count is at most MAX_CHANNELS: scale by shift and add
	always_comb begin
		pos    = PSW'(row_sel) * PSW'(s_eff) + PSW'(col_sel);
		scaled = '0;
		for (int i = 0; i < CEW; i++) begin
			if (c_eff[i]) scaled = scaled + (OFW'(pos) << i);
		end
		off_full = scaled + OFW'(ch_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_size_q    <= TILE_SIZE_RST;
			tiles_across_q <= TILES_ACROSS_RST;
			tiles_down_q   <= TILES_DOWN_RST;
			channels_q     <= CHANNELS_RST;
			rotate_q       <= 1'b0;
			mirror_q       <= 1'b0;
			chan_q         <= '0;
			col_q          <= '0;
			row_q          <= '0;
			tcol_q         <= '0;
			trow_q         <= '0;
			k_q            <= '0;
		end else if (cfg_hit) begin
			case (cfg_index)
				CFG_TILE_SIZE:    tile_size_q    <= cfg_data[4:0];
				CFG_TILES_ACROSS: tiles_across_q <= cfg_data[8:0];
				CFG_TILES_DOWN:   tiles_down_q   <= cfg_data[8:0];
				CFG_CHANNELS:     channels_q     <= cfg_data[2:0];
				CFG_ROTATE_ON:    rotate_q       <= cfg_data[0];
				CFG_MIRROR_ON:    mirror_q       <= cfg_data[0];
				default: ;
			endcase
			chan_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
			tcol_q <= '0;
			trow_q <= '0;
			k_q    <= '0;
		end else if (cmd.accept) begin
			if (!last_c) begin
				chan_q <= chan_q + 1'b1;
			end else begin
				chan_q <= '0;
				if (!last_x) begin
					col_q <= col_q + 1'b1;
				end else begin
					col_q <= '0;
					if (!last_y) begin
						row_q <= row_q + 1'b1;
					end else begin
						row_q <= '0;
						k_q   <= done ? '0 : k_q + 1'b1;
						if (!last_tc) begin
							tcol_q <= tcol_q + 1'b1;
						end else begin
							tcol_q <= '0;
							trow_q <= last_tr ? '0 : trow_q + 1'b1;
						end
					end
				end
			end
		end
	end

	// item and output registers carry payload only
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= s_tdata;
			x_q    <= col_q;
			y_q    <= row_q;
			ch_q   <= chan_q;
			kit_q  <= k_q;
			done_q <= done;
		end
		if (cmd.load) begin
			tile_q    <= rotate_q ? TILE_NUM_W'({kit_q, cmd.orient}) : TILE_NUM_W'(kit_q);
			off_q     <= off_full[BYTE_OFF_W-1:0];
			obyte_q   <= byte_q;
			last_q    <= !rotate_q || (cmd.orient == ORIENT_LAST);
			imgdone_q <= done_q;
		end
	end

	assign m_tdata = {4'b0000, obyte_q, off_q, tile_q};
	assign m_tlast = last_q;
	assign m_tuser = imgdone_q;

endmodule

[src/tile_rotation_sampler_top.sv]
// Top level of the tile sampler: controller plus datapath.
//
//  channel | direction | beat contents
//  --------+-----------+-----------------------------------------------------
//  s_*     | in        | s_tdata: one source byte in tile-major order
//  m_*     | out       | m_tdata: tile number, byte offset, byte; tlast: final
//          |           | write of a byte; tuser: byte ends the image
//  cfg_*   | in        | cfg_index selects register, cfg_data its new value
//
// Beats: each source byte makes one output beat (four with rotation); the
// single output register is loaded once a cycle while the sink does not stall.
// A byte entering an idle block is latched into the item register before its
// first write is loaded.
// Reset: asynchronous, clears counters, state machine and output valid;
// registers return to tile size 3, one tile across and down, 3 channels, no rotation or mirror.
// Stalls: m_tready low holds the output beat and the orientation sequence;
// the next source byte is taken with the final write of the current one.
// Config writes are always accepted; a write to a mapped register restarts the
// image from its first byte, an unmapped index is dropped.
module tile_rotation_sampler_top #(
	parameter int MAX_TILE_SIZE  = trs_pkg::MAX_TILE_SIZE_DEF,
	parameter int MAX_TILES_EDGE = trs_pkg::MAX_TILES_EDGE_DEF,
	parameter int MAX_CHANNELS   = trs_pkg::MAX_CHANNELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [trs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [trs_pkg::CFG_DATA_W-1:0] cfg_data,
	// source bytes
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [trs_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] src_byte
	// tile writes
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [trs_pkg::M_TDATA_W-1:0]  m_tdata,   // [17:0] tile_number,
	                                                  // [27:18] byte_offset,
	                                                  // [35:28] out_byte, rest 0
	output logic                           m_tlast,
	output logic                           m_tuser    // [0] image_done
);
	import trs_pkg::*;

	trs_cmd_t  cmd;
	trs_stat_t stat;

	// register file never back-pressures
	assign cfg_ready = 1'b1;

	trs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	trs_dpath #(
		.MAX_TILE_SIZE  (MAX_TILE_SIZE),
		.MAX_TILES_EDGE (MAX_TILES_EDGE),
		.MAX_CHANNELS   (MAX_CHANNELS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for tile_rotation_sampler_top: predicts every tile write from the source bytes.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import trs_pkg::*;

	// indexes outside the register map; a write there must leave the counters alone
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_7 = 3'd7;

	localparam int SETTLE_CYCLES = 3;    // quiet cycles before a register write
	localparam int HOLD_CYCLES   = 80;   // long sink hold-off, backs up the source side
	localparam int TAIL_CYCLES   = 16;

	typedef struct packed {
		logic [TILE_NUM_W-1:0] tile;
		logic [BYTE_OFF_W-1:0] offset;
		logic [BYTE_W-1:0]     value;
		logic                  is_last;
		logic                  done;
	} tile_write_t;

	// one entry of the stimulus: either a source byte or a register write
	typedef struct {
		bit                    is_reg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [BYTE_W-1:0]     value;
	} plan_item_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;

	tile_rotation_sampler_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// ---------------------------------------------------------------
	// Predictor: register copy and tile-position counters
	// ---------------------------------------------------------------
	logic [4:0] tile_size_r    = TILE_SIZE_RST;
	logic [8:0] tiles_across_r = TILES_ACROSS_RST;
	logic [8:0] tiles_down_r   = TILES_DOWN_RST;
	logic [2:0] channels_r     = CHANNELS_RST;
	logic       rotate_r       = 1'b0;
	logic       mirror_r       = 1'b0;

	logic [1:0] chan_cnt = '0;
	logic [3:0] col_cnt  = '0;
	logic [3:0] row_cnt  = '0;
	logic [7:0] tcol_cnt = '0;
	logic [7:0] trow_cnt = '0;

	tile_write_t awaited_writes[$];
	plan_item_t  byte_plan[$];

	int errors       = 0;
	int bytes_in     = 0;
	int reg_writes   = 0;
	int writes_seen  = 0;
	int rotated_bytes = 0;
	int mirrored_bytes = 0;
	int image_ends   = 0;

	// zero counts as one, anything past the maximum as the maximum
	function automatic int unsigned fit(input int unsigned v, input int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void add_write(input int unsigned tile, input int unsigned col,
	                                  input int unsigned row, input int unsigned s,
	                                  input int unsigned c, input logic [BYTE_W-1:0] value,
	                                  input bit is_last, input bit done);
		tile_write_t w;
		int unsigned off;
		off = (row * s + col) * c + chan_cnt;
		w.tile    = tile[TILE_NUM_W-1:0];
		w.offset  = off[BYTE_OFF_W-1:0];
		w.value   = value;
		w.is_last = is_last;
		w.done    = done;
		awaited_writes = {awaited_writes, w};
	endfunction

	function automatic void predict_tile_writes(input logic [BYTE_W-1:0] value);
		int unsigned s, ta, td, c, x, y, m, k;
		bit lc, lx, ly, ltc, ltr, done;
		s  = fit(tile_size_r, MAX_TILE_SIZE_DEF);
		ta = fit(tiles_across_r, MAX_TILES_EDGE_DEF);
		td = fit(tiles_down_r, MAX_TILES_EDGE_DEF);
		c  = fit(channels_r, MAX_CHANNELS_DEF);

		if (chan_cnt >= c) chan_cnt = '0;
		if (col_cnt >= s) col_cnt = '0;
		if (row_cnt >= s) row_cnt = '0;
		if (tcol_cnt >= ta) tcol_cnt = '0;
		if (trow_cnt >= td) trow_cnt = '0;

		x = col_cnt;
		y = row_cnt;
		m = s - 1;
		k = trow_cnt * ta + tcol_cnt;

		lc   = (chan_cnt + 1 >= c);
		lx   = (x + 1 >= s);
		ly   = (y + 1 >= s);
		ltc  = (tcol_cnt + 1 >= ta);
		ltr  = (trow_cnt + 1 >= td);
		done = lc && lx && ly && ltc && ltr;
		if (done) image_ends++;

		if (rotate_r) begin
			rotated_bytes++;
			add_write(4 * k + 0, x, y, s, c, value, 1'b0, done);
			add_write(4 * k + 1, m - y, x, s, c, value, 1'b0, done);
			if (mirror_r) begin
				mirrored_bytes++;
				add_write(4 * k + 2, x, m - y, s, c, value, 1'b0, done);
			end else begin
				add_write(4 * k + 2, m - x, m - y, s, c, value, 1'b0, done);
			end
			add_write(4 * k + 3, y, m - x, s, c, value, 1'b1, done);
		end else begin
			add_write(k, x, y, s, c, value, 1'b1, done);
		end

		// channel, column, row, tile column, tile row
		if (!lc) begin
			chan_cnt++;
			return;
		end
		chan_cnt = '0;
		if (!lx) begin
			col_cnt++;
			return;
		end
		col_cnt = '0;
		if (!ly) begin
			row_cnt++;
			return;
		end
		row_cnt = '0;
		if (!ltc) begin
			tcol_cnt++;
			return;
		end
		tcol_cnt = '0;
		if (!ltr) begin
			trow_cnt++;
			return;
		end
		trow_cnt = '0;
	endfunction

	function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
	                                        input logic [CFG_DATA_W-1:0] d);
		case (idx)
			CFG_TILE_SIZE:    tile_size_r    = d[4:0];
			CFG_TILES_ACROSS: tiles_across_r = d;
			CFG_TILES_DOWN:   tiles_down_r   = d;
			CFG_CHANNELS:     channels_r     = d[2:0];
			CFG_ROTATE_ON:    rotate_r       = d[0];
			CFG_MIRROR_ON:    mirror_r       = d[0];
			default:          return;   // unmapped: counters kept
		endcase
		// every mapped write restarts the image
		chan_cnt = '0;
		col_cnt  = '0;
		row_cnt  = '0;
		tcol_cnt = '0;
		trow_cnt = '0;
	endfunction

	// ---------------------------------------------------------------
	// Driver: source bytes in bursts, register writes only when idle
	// ---------------------------------------------------------------
	int burst_left = 0;
	int gap_left   = 0;
	int settle_cnt = 0;

	always @(posedge clk or negedge arst_n) begin
		plan_item_t            item;
		logic                  nxt_sv, nxt_cv;
		logic [BYTE_W-1:0]     nxt_byte;
		logic [CFG_IDX_W-1:0]  nxt_idx;
		logic [CFG_DATA_W-1:0] nxt_dat;
		if (!arst_n) begin
			s_tvalid  <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			nxt_sv   = s_tvalid;
			nxt_cv   = cfg_valid;
			nxt_byte = s_tdata;
			nxt_idx  = cfg_index;
			nxt_dat  = cfg_data;

			if (s_tvalid && s_tready) begin
				predict_tile_writes(s_tdata);
				bytes_in++;
				nxt_sv = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				apply_reg_write(cfg_index, cfg_data);
				reg_writes++;
				nxt_cv = 1'b0;
			end

			// the block is idle once nothing is offered and every write has come back
			if (!s_tvalid && !cfg_valid && awaited_writes.size() == 0)
				settle_cnt++;
			else
				settle_cnt = 0;

			if (!nxt_sv && !nxt_cv && byte_plan.size() != 0) begin
				if (byte_plan[0].is_reg) begin
					if (settle_cnt >= SETTLE_CYCLES) begin
						item     = byte_plan.pop_front();
						nxt_cv   = 1'b1;
						nxt_idx  = item.idx;
						nxt_dat  = item.data;
						settle_cnt = 0;
					end
				end else if (gap_left != 0) begin
					gap_left--;
				end else begin
					item     = byte_plan.pop_front();
					nxt_sv   = 1'b1;
					nxt_byte = item.value;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						// new burst; about a quarter of them follow with no gap at all
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
					end
				end
			end

			s_tvalid  <= nxt_sv;
			s_tdata   <= nxt_byte;
			cfg_valid <= nxt_cv;
			cfg_index <= nxt_idx;
			cfg_data  <= nxt_dat;
		end
	end

	// ---------------------------------------------------------------
	// Sink: rotating stall patterns plus occasional long hold-offs
	// ---------------------------------------------------------------
	int sink_cycle   = 0;
	int sink_beats   = 0;
	int hold_left    = 0;
	int next_hold_at = 150;

	always @(posedge clk or negedge arst_n) begin
		logic nxt_rdy;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			sink_cycle++;
			if (m_tvalid && m_tready)
				sink_beats++;
			if (hold_left != 0) begin
				hold_left--;
				nxt_rdy = 1'b0;
			end else if (sink_beats >= next_hold_at && s_tvalid) begin
				// start the hold-off while the source is offering, so its side backs up
				hold_left    = HOLD_CYCLES;
				next_hold_at = sink_beats + 500;
				nxt_rdy      = 1'b0;
			end else begin
				case ((sink_cycle / 64) % 4)
					0: nxt_rdy = 1'b1;
					1: nxt_rdy = 1'($urandom_range(0, 1));
					2: nxt_rdy = ($urandom_range(0, 3) == 0);
					default: nxt_rdy = (sink_cycle % 3 == 0);
				endcase
			end
			m_tready <= nxt_rdy;
		end
	end

	// ---------------------------------------------------------------
	// Monitor: each write beat against the oldest prediction
	// ---------------------------------------------------------------
	task automatic compare_field(input string name, input int unsigned exp_v,
	                             input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("write %0d: %s expected 0x%0h, got 0x%0h", writes_seen, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		tile_write_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_writes.size() == 0) begin
				$error("write beat with nothing predicted: tdata 0x%0h", m_tdata);
				errors++;
			end else begin
				w = awaited_writes.pop_front();
				compare_field("tile_number", w.tile, m_tdata[17:0]);
				compare_field("byte_offset", w.offset, m_tdata[27:18]);
				compare_field("out_byte", w.value, m_tdata[35:28]);
				compare_field("tdata_pad", 0, m_tdata[M_TDATA_W-1:36]);
				compare_field("last", w.is_last, m_tlast);
				compare_field("image_done", w.done, m_tuser);
			end
			writes_seen++;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus plan
	// ---------------------------------------------------------------
	function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx,
	                                 input logic [CFG_DATA_W-1:0] d);
		plan_item_t it;
		it.is_reg = 1'b1;
		it.idx    = idx;
		it.data   = d;
		it.value  = '0;
		byte_plan = {byte_plan, it};
	endfunction

	function automatic void plan_byte(input logic [BYTE_W-1:0] v);
		plan_item_t it;
		it.is_reg = 1'b0;
		it.idx    = '0;
		it.data   = '0;
		it.value  = v;
		byte_plan = {byte_plan, it};
	endfunction

	initial begin
		int unsigned p_ts, p_ta, p_td, p_ch, n_new, img, n;
		int planned;
		logic [CFG_DATA_W-1:0] v;

		// reset settings: 3x3 tile, 3 channels, one tile, no rotation
		plan_byte(8'h00);
		plan_byte(8'hFF);
		// unmapped index mid-image: pixel position must carry on
		plan_reg(CFG_UNUSED_7, 9'h1FF);
		plan_byte(8'h5A);
		// everything above range: clamps to 16, 4 channels, 256x256 tiles; only bit 0 of flags
		plan_reg(CFG_TILE_SIZE, 9'h1FF);
		plan_reg(CFG_CHANNELS, 9'h1FF);
		plan_reg(CFG_ROTATE_ON, 9'h1FF);
		plan_reg(CFG_MIRROR_ON, 9'h1FE);
		plan_reg(CFG_TILES_ACROSS, 9'h1FF);
		plan_reg(CFG_TILES_DOWN, 9'h1FF);
		repeat (3) plan_byte(BYTE_W'($urandom_range(0, 255)));
		// rotation with mirror
		plan_reg(CFG_MIRROR_ON, 9'h001);
		repeat (2) plan_byte(BYTE_W'($urandom_range(0, 255)));
		// mirror alone does nothing
		plan_reg(CFG_ROTATE_ON, 9'h100);
		repeat (2) plan_byte(BYTE_W'($urandom_range(0, 255)));
		// zeros count as one: 1x1 pixel tiles, one channel, two tiles down -> two-byte image
		plan_reg(CFG_TILE_SIZE, 9'h000);
		plan_reg(CFG_CHANNELS, 9'h000);
		plan_reg(CFG_TILES_ACROSS, 9'h000);
		plan_reg(CFG_TILES_DOWN, 9'd2);
		plan_reg(CFG_ROTATE_ON, 9'h001);
		plan_reg(CFG_MIRROR_ON, 9'h000);
		repeat (3) plan_byte(BYTE_W'($urandom_range(0, 255)));   // ends the image, then wraps
		plan_reg(CFG_UNUSED_6, 9'h0AA);
		plan_byte(BYTE_W'($urandom_range(0, 255)));
		// 2x2 single tile, rotated and mirrored, one full image
		plan_reg(CFG_TILE_SIZE, 9'd2);
		plan_reg(CFG_TILES_DOWN, 9'd1);
		plan_reg(CFG_MIRROR_ON, 9'h001);
		repeat (4) plan_byte(BYTE_W'($urandom_range(0, 255)));

		// random phases: mostly small images that run to completion
		p_ts = 2; p_ta = 1; p_td = 1; p_ch = 1;
		planned = 18;
		while (planned < 330) begin
			n_new = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 3);
			if ($urandom_range(0, 3) != 0) begin
				plan_reg(CFG_TILE_SIZE, CFG_DATA_W'(n_new));
				p_ts = n_new;
			end
			n_new = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 3);
			if ($urandom_range(0, 3) != 0) begin
				plan_reg(CFG_TILES_ACROSS, CFG_DATA_W'(n_new));
				p_ta = n_new;
			end
			n_new = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 2);
			if ($urandom_range(0, 3) != 0) begin
				plan_reg(CFG_TILES_DOWN, CFG_DATA_W'(n_new));
				p_td = n_new;
			end
			n_new = $urandom_range(0, 7);
			if ($urandom_range(0, 3) != 0) begin
				plan_reg(CFG_CHANNELS, CFG_DATA_W'(n_new));
				p_ch = n_new;
			end
			v = CFG_DATA_W'($urandom_range(0, 511));
			if ($urandom_range(0, 2) != 0) plan_reg(CFG_ROTATE_ON, v);
			v = CFG_DATA_W'($urandom_range(0, 511));
			if ($urandom_range(0, 2) != 0) plan_reg(CFG_MIRROR_ON, v);
			if ($urandom_range(0, 7) == 0)
				plan_reg($urandom_range(0, 1) ? CFG_UNUSED_6 : CFG_UNUSED_7,
				         CFG_DATA_W'($urandom_range(0, 511)));

			img = fit(p_ts, MAX_TILE_SIZE_DEF) * fit(p_ts, MAX_TILE_SIZE_DEF) *
			      fit(p_ch, MAX_CHANNELS_DEF) * fit(p_ta, MAX_TILES_EDGE_DEF) *
			      fit(p_td, MAX_TILES_EDGE_DEF);
			// whole images (sometimes two, plus a few bytes into the next) when they are short
			n = (img <= 48) ? img * $urandom_range(1, 2) + $urandom_range(0, 3)
			                : $urandom_range(8, 40);
			if (n > 60) n = 60;
			repeat (n) plan_byte(BYTE_W'($urandom_range(0, 255)));
			planned += n;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (byte_plan.size() != 0 || s_tvalid || cfg_valid)
			@(posedge clk);
		for (int i = 0; i < 20000 && awaited_writes.size() != 0; i++)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_writes.size() != 0) begin
			$error("%0d predicted writes never came out", awaited_writes.size());
			errors++;
		end

		$display("Run covered %0d source bytes (%0d rotated, %0d mirrored), %0d tile writes,",
		         bytes_in, rotated_bytes, mirrored_bytes, writes_seen);
		$display("%0d register writes and %0d completed images.", reg_writes, image_ends);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
src/trs_pkg.sv
src/trs_ctrl.sv
src/trs_dpath.sv
src/tile_rotation_sampler_top.sv
tb/sv/tb.sv
